>>> sv/epr_pkg.sv
// ----------------------------------------------------------------------------
// epr_pkg: shared types and constants for the Euler point rotator
// Fixed-point widths, CORDIC arctangent table, config register indexes.
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int unsigned CordicSteps = 30;
  localparam logic [31:0] DegToPhase  = 32'd11930465;
  localparam logic [31:0] RadToPhase  = 32'd683565276;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] Q30One     = 34'sd1073741824;
  localparam int unsigned QueueDepth = 4;

  localparam logic [0:0] RegAnglesInDegrees = 1'b0;
  localparam logic [0:0] RegCounterClockwise = 1'b1;

  typedef logic signed [31:0] coord_t;

  // One classified word as handed from front to back.
  typedef struct packed {
    logic signed [32:0] tx;
    logic signed [32:0] ty;
    logic signed [32:0] tz;
    logic [31:0] ph_phi;
    logic [31:0] ph_theta;
    logic [31:0] ph_psi;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    logic ccw;
  } epr_word_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/euler_point_rotator.sv
// ----------------------------------------------------------------------------
// euler_point_rotator: rotate a point about a center by three Euler angles
//
// Channel  Dir  Handshake                Payload
// in       in   in_valid_i / in_ready_o  point, angles, center (Q16.16)
// out      out  out_valid_o / out_ready_i rotated_x/y/z (Q16.16, saturated)
// cfg      in   cfg_we_i                 cfg_index_i, cfg_data_i
//
// One word per cycle while the output is not stalled. Path: 2 front stages, the
// queue memory, a CORDIC preload stage, 30 CORDIC stages and 7 rotation stages;
// the CORDIC pipeline sets the depth.
// Reset clears valids and sets radians, counter-clockwise.
// A stalled output holds the whole back pipeline; the queue absorbs the front.
// ----------------------------------------------------------------------------
module euler_point_rotator import epr_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  logic   cfg_index_i,
  input  logic   cfg_data_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  coord_t point_x_i,
  input  coord_t point_y_i,
  input  coord_t point_z_i,
  input  coord_t angle_phi_i,
  input  coord_t angle_theta_i,
  input  coord_t angle_psi_i,
  input  coord_t center_x_i,
  input  coord_t center_y_i,
  input  coord_t center_z_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output coord_t rotated_x_o,
  output coord_t rotated_y_o,
  output coord_t rotated_z_o
);

  logic deg_q, ccw_q;
  logic fv, fr, qv, qr;
  epr_word_t fw, qw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= 1'b0;
      ccw_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegAnglesInDegrees) deg_q <= cfg_data_i;
      if (cfg_index_i == RegCounterClockwise) ccw_q <= cfg_data_i;
    end
  end

  epr_front u_front (
    .clk_i, .rst_ni, .degrees_i(deg_q), .ccw_i(ccw_q),
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .point_x_i, .point_y_i, .point_z_i,
    .angle_phi_i, .angle_theta_i, .angle_psi_i,
    .center_x_i, .center_y_i, .center_z_i,
    .valid_o(fv), .ready_i(fr), .word_o(fw)
  );

  epr_queue #(.Depth(QDepth)) u_queue (
    .clk_i, .rst_ni, .valid_i(fv), .ready_o(fr), .word_i(fw),
    .valid_o(qv), .ready_i(qr), .word_o(qw)
  );

  epr_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .ready_o(qr), .word_i(qw),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .rotated_x_o, .rotated_y_o, .rotated_z_o
  );

endmodule

>>> sv/epr_front.sv
// ----------------------------------------------------------------------------
// epr_front: input stage
// Accepts a word, subtracts the center and converts the angles to phases.
// Two stages: multiply by unit constant, then round to phase.
// ----------------------------------------------------------------------------
module epr_front import epr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      degrees_i,
  input  logic      ccw_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  coord_t    point_x_i,
  input  coord_t    point_y_i,
  input  coord_t    point_z_i,
  input  coord_t    angle_phi_i,
  input  coord_t    angle_theta_i,
  input  coord_t    angle_psi_i,
  input  coord_t    center_x_i,
  input  coord_t    center_y_i,
  input  coord_t    center_z_i,
  output logic      valid_o,
  input  logic      ready_i,
  output epr_word_t word_o
);

  logic        v0_q, v1_q;
  logic [63:0] p_phi_q, p_theta_q, p_psi_q;
  logic [31:0] k;
  epr_word_t   w0_q, w1_q, w1_d;
  logic        adv1, adv0;

  assign k = degrees_i ? DegToPhase : RadToPhase;
  assign adv1 = !v1_q || ready_i;
  assign adv0 = !v0_q || adv1;
  assign ready_o = adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= valid_i;
      if (adv1) v1_q <= v0_q;
    end
  end

  always_comb begin
    w1_d = w0_q;
    w1_d.ph_phi   = 32'((p_phi_q + 64'd32768) >> 16);
    w1_d.ph_theta = 32'((p_theta_q + 64'd32768) >> 16);
    w1_d.ph_psi   = 32'((p_psi_q + 64'd32768) >> 16);
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      w0_q.tx <= 33'(point_x_i) - 33'(center_x_i);
      w0_q.ty <= 33'(point_y_i) - 33'(center_y_i);
      w0_q.tz <= 33'(point_z_i) - 33'(center_z_i);
      w0_q.cx <= center_x_i;
      w0_q.cy <= center_y_i;
      w0_q.cz <= center_z_i;
      w0_q.ccw <= ccw_i;
      w0_q.ph_phi <= '0;
      w0_q.ph_theta <= '0;
      w0_q.ph_psi <= '0;
      p_phi_q   <= 64'(signed'(angle_phi_i)) * 64'(k);
      p_theta_q <= 64'(signed'(angle_theta_i)) * 64'(k);
      p_psi_q   <= 64'(signed'(angle_psi_i)) * 64'(k);
    end
    if (adv1) begin
      w1_q <= w1_d;
    end
  end

  assign valid_o = v1_q;
  assign word_o  = w1_q;

endmodule

>>> sv/epr_queue.sv
// ----------------------------------------------------------------------------
// epr_queue: short FIFO between front and back
// Decouples the two halves so each may stall on its own.
// ----------------------------------------------------------------------------
module epr_queue import epr_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  epr_word_t word_i,
  output logic      valid_o,
  input  logic      ready_i,
  output epr_word_t word_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  epr_word_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic push, pop;

  assign ready_o = cnt_q != (AW+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign push = valid_i && ready_o;
  assign pop  = valid_o && ready_i;
  assign word_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= word_i;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count step");
  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("count drop");
`endif

endmodule

>>> sv/epr_back.sv
// ----------------------------------------------------------------------------
// epr_back: pipelined sine/cosine and rotation datapath
// 30 CORDIC stages for the three angles, then three rotation stages,
// each with a multiply register and a sum register, then saturation.
// ----------------------------------------------------------------------------
module epr_back import epr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  epr_word_t word_i,
  output logic      valid_o,
  input  logic      ready_i,
  output coord_t    rotated_x_o,
  output coord_t    rotated_y_o,
  output coord_t    rotated_z_o
);

  localparam int unsigned NS = CordicSteps + 7;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic flip;
  } cs_t;

  typedef struct packed {
    logic signed [33:0] s;
    logic signed [33:0] c;
  } sc_t;

  logic [NS:0] v_q;
  logic adv;
  assign adv = !v_q[NS] || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[NS-1:0], valid_i};
  end

  // CORDIC preload
  function automatic cs_t cs_init(input logic [31:0] ph);
    cs_t r;
    logic signed [32:0] z;
    z = 33'(signed'(ph));
    r.flip = 1'b0;
    if (z > 33'sd1073741824) begin
      z = z - 33'sd2147483648;
      r.flip = 1'b1;
    end else if (z < -33'sd1073741824) begin
      z = z + 33'sd2147483648;
      r.flip = 1'b1;
    end
    r.x = CordicGain;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

  function automatic cs_t cs_step(input cs_t a, input logic [4:0] i);
    cs_t r;
    logic signed [33:0] dx, dy;
    logic signed [32:0] t;
    dx = a.y >>> i;
    dy = a.x >>> i;
    t = 33'(atan_turn(i));
    r = a;
    if (!a.z[32]) begin
      r.x = a.x - dx; r.y = a.y + dy; r.z = a.z - t;
    end else begin
      r.x = a.x + dx; r.y = a.y - dy; r.z = a.z + t;
    end
    return r;
  endfunction

  function automatic logic signed [33:0] clamp30(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = v;
    if (v > Q30One) r = Q30One;
    if (v < -Q30One) r = -Q30One;
    return r;
  endfunction

  function automatic sc_t cs_final(input cs_t a, input logic ccw);
    sc_t r;
    logic signed [33:0] x, y;
    x = a.flip ? -a.x : a.x;
    y = a.flip ? -a.y : a.y;
    if (!ccw) y = -y;
    r.s = clamp30(y);
    r.c = clamp30(x);
    return r;
  endfunction

  cs_t cp_q [3][CordicSteps+1];
  epr_word_t wc_q [CordicSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cp_q[0][0] <= cs_init(word_i.ph_phi);
      cp_q[1][0] <= cs_init(word_i.ph_theta);
      cp_q[2][0] <= cs_init(word_i.ph_psi);
      wc_q[0] <= word_i;
      for (int s = 0; s < CordicSteps; s++) begin
        for (int a = 0; a < 3; a++) begin
          cp_q[a][s+1] <= cs_step(cp_q[a][s], 5'(s));
        end
        wc_q[s+1] <= wc_q[s];
      end
    end
  end

  // rotation stages: each has a multiply stage and an add stage
  sc_t st_q, ss_q, st2_q, ss2_q, ss3_q, ss4_q, ss5_q;
  logic signed [63:0] m1a_q, m1b_q, m1c_q, m1d_q;
  logic signed [63:0] m2a_q, m2b_q, m2c_q, m2d_q;
  logic signed [63:0] m3a_q, m3b_q, m3c_q, m3d_q;
  logic signed [32:0] txa_q, txb_q;
  logic signed [35:0] y1_q, z1_q, x2_q, z2_q, y1b_q, y1c_q, x3_q, y3_q, z2b_q, z2c_q;
  logic signed [31:0] cxa_q [6];
  logic signed [31:0] cya_q [6];
  logic signed [31:0] cza_q [6];
  coord_t ox_q, oy_q, oz_q;
  epr_word_t wl;
  sc_t sc0, sc1, sc2;

  assign wl  = wc_q[CordicSteps];
  assign sc0 = cs_final(cp_q[0][CordicSteps], wl.ccw);
  assign sc1 = cs_final(cp_q[1][CordicSteps], wl.ccw);
  assign sc2 = cs_final(cp_q[2][CordicSteps], wl.ccw);

  function automatic logic signed [35:0] rq(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return 36'(t);
  endfunction

  function automatic coord_t sat32(input logic signed [36:0] v);
    coord_t r;
    if (v > 37'sd2147483647) r = 32'sh7fffffff;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage A: x-axis products
      m1a_q <= 64'(wl.ty) * 64'(sc0.c);
      m1b_q <= 64'(wl.tz) * 64'(sc0.s);
      m1c_q <= 64'(wl.ty) * 64'(-sc0.s);
      m1d_q <= 64'(wl.tz) * 64'(sc0.c);
      txa_q <= wl.tx;
      st_q <= sc1;
      ss_q <= sc2;
      cxa_q[0] <= wl.cx; cya_q[0] <= wl.cy; cza_q[0] <= wl.cz;
      // stage B
      y1_q <= rq(m1a_q) + rq(m1b_q);
      z1_q <= rq(m1c_q) + rq(m1d_q);
      txb_q <= txa_q;
      st2_q <= st_q;
      ss2_q <= ss_q;
      // stage C: y-axis products
      m2a_q <= 64'(txb_q) * 64'(st2_q.c);
      m2b_q <= 64'(z1_q) * 64'(-st2_q.s);
      m2c_q <= 64'(txb_q) * 64'(st2_q.s);
      m2d_q <= 64'(z1_q) * 64'(st2_q.c);
      y1b_q <= y1_q;
      ss3_q <= ss2_q;
      // stage D
      x2_q <= rq(m2a_q) + rq(m2b_q);
      z2_q <= rq(m2c_q) + rq(m2d_q);
      y1c_q <= y1b_q;
      ss4_q <= ss3_q;
      // stage E: z-axis products
      m3a_q <= 64'(x2_q) * 64'(ss4_q.c);
      m3b_q <= 64'(y1c_q) * 64'(ss4_q.s);
      m3c_q <= 64'(x2_q) * 64'(-ss4_q.s);
      m3d_q <= 64'(y1c_q) * 64'(ss4_q.c);
      z2b_q <= z2_q;
      ss5_q <= ss4_q;
      // stage F
      x3_q <= rq(m3a_q) + rq(m3b_q);
      y3_q <= rq(m3c_q) + rq(m3d_q);
      z2c_q <= z2b_q;
      // stage G: add center and saturate
      ox_q <= sat32(37'(x3_q) + 37'(cxa_q[5]));
      oy_q <= sat32(37'(y3_q) + 37'(cya_q[5]));
      oz_q <= sat32(37'(z2c_q) + 37'(cza_q[5]));
      for (int i = 0; i < 5; i++) begin
        cxa_q[i+1] <= cxa_q[i]; cya_q[i+1] <= cya_q[i]; cza_q[i+1] <= cza_q[i];
      end
    end
  end

  assign valid_o = v_q[NS];
  assign rotated_x_o = ox_q;
  assign rotated_y_o = oy_q;
  assign rotated_z_o = oz_q;

endmodule
